FILE: rtl/bha_pkg.sv
// Block heap allocator: shared constants, operation and status codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bha_pkg;

   localparam int OWN_W = 8;
   localparam int OP_W  = 3;
   localparam int ST_W  = 3;

   localparam int DEF_MAX_BLOCKS    = 64;
   localparam int DEF_MAX_HEAP_BYTES = 131072;

   localparam int HDR_BYTES   = 16;
   localparam int SPLIT_MIN   = 24;
   localparam int MIN_PAYLOAD = 8;
   localparam int HEAP_MIN    = 2048;
   localparam int HEAP_RESET  = 65536;
   localparam int OWNER_MAX   = 25;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC     = 3'd0,
      OP_FREE      = 3'd1,
      OP_FREE_OWN  = 3'd2,
      OP_EXISTS    = 3'd3,
      OP_RENAME    = 3'd4,
      OP_CHECK     = 3'd5
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK       = 3'd0,
      ST_BAD_REQ  = 3'd1,
      ST_NO_FIT   = 3'd2,
      ST_BAD_FREE = 3'd3,
      ST_INCONS   = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   localparam logic CSR_FIT_MODE  = 1'b0;
   localparam logic CSR_HEAP_SIZE = 1'b1;

endpackage

FILE: rtl/bha_ifs.sv
// Block heap allocator: request and response channel interfaces.
// Depends on bha_pkg for field widths.
`timescale 1ns / 1ps

interface bha_req_if #(parameter int LEN_W = 18, parameter int OFF_W = 17);
   import bha_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [LEN_W-1:0]    request_bytes;
   logic [OWN_W-1:0]    owner_id;
   logic [OWN_W-1:0]    new_owner_id;
   logic [OFF_W-1:0]    payload_offset;
   modport source (output valid, operation, request_bytes, owner_id, new_owner_id,
                   payload_offset, input ready);
   modport sink   (input valid, operation, request_bytes, owner_id, new_owner_id,
                   payload_offset, output ready);
endinterface

interface bha_rsp_if #(parameter int LEN_W = 18, parameter int OFF_W = 17);
   import bha_pkg::*;
   logic                valid;
   logic                ready;
   logic [ST_W-1:0]     status;
   logic [OFF_W-1:0]    result_offset;
   logic                found;
   logic [LEN_W-1:0]    free_total;
   modport source (output valid, status, result_offset, found, free_total, input ready);
   modport sink   (input valid, status, result_offset, found, free_total, output ready);
endinterface

FILE: rtl/bha_engine.sv
// Block heap allocator: block table memory and the sequencer that walks it.
// Depends on bha_pkg and bha_ifs; configuration comes from the top level.
`timescale 1ns / 1ps

module bha_engine #(
   parameter int MAX_BLOCKS     = bha_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_HEAP_BYTES = bha_pkg::DEF_MAX_HEAP_BYTES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fit_mode,
   input  logic [$clog2(MAX_HEAP_BYTES+1)-1:0]    heap_bytes,
   input  logic                                   init_req,
   output logic                                   init_ack,
   bha_req_if.sink                                req,
   bha_rsp_if.source                              rsp
);
   import bha_pkg::*;

   localparam int LEN_W = $clog2(MAX_HEAP_BYTES+1);
   localparam int OFF_W = $clog2(MAX_HEAP_BYTES);
   localparam int SZ_W  = LEN_W + 1;
   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS+1);
   localparam int SUM_W = LEN_W + IDX_W + 1;
   localparam int ENT_W = OFF_W + LEN_W + OWN_W;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_INIT     = 12'b000000000010,
      S_SCAN     = 12'b000000000100,
      S_DECIDE   = 12'b000000001000,
      S_TAKE     = 12'b000000010000,
      S_SHRD     = 12'b000000100000,
      S_SHWR     = 12'b000001000000,
      S_SPLIT_HI = 12'b000010000000,
      S_SPLIT_LO = 12'b000100000000,
      S_PASS     = 12'b001000000000,
      S_PASSEND  = 12'b010000000000,
      S_RESP     = 12'b100000000000
   } state_type;

   // table memory
   logic [ENT_W-1:0] mem [MAX_BLOCKS];
   logic [ENT_W-1:0] rdata_ff;
   logic [IDX_W-1:0] raddr, waddr;
   logic [ENT_W-1:0] wdata;
   logic             we;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SZ_W-1:0]   size_ff, size_in;
   logic [OWN_W-1:0]  own_ff, own_in, nown_ff, nown_in;
   logic [OFF_W-1:0]  pay_ff, pay_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, rd_ff, rd_in, j_ff, j_in;
   logic              dv_ff, dv_in;
   logic [IDX_W-1:0]  ep_ff, ep_in, best_ff, best_in, wr_ff, wr_in;
   logic              have_ff, have_in, stop_ff, stop_in, hit_ff, hit_in, bad_ff, bad_in;
   logic [OFF_W-1:0]  bstart_ff, bstart_in;
   logic [LEN_W-1:0]  blen_ff, blen_in;
   logic [OWN_W-1:0]  hown_ff, hown_in;
   logic [SUM_W-1:0]  pos_ff, pos_in, used_ff, used_in, unused_ff, unused_in;
   logic [ENT_W-1:0]  pend_ff, pend_in;
   logic              phave_ff, phave_in;
   logic              rv_ff, rv_in, rfound_ff, rfound_in;
   logic [ST_W-1:0]   rst_ff, rst_in;
   logic [OFF_W-1:0]  roff_ff, roff_in;
   logic [LEN_W-1:0]  rfree_ff, rfree_in;

   logic              acc;
   logic [OFF_W-1:0]  e_start;
   logic [LEN_W-1:0]  e_len;
   logic [OWN_W-1:0]  e_own, t_own;
   logic [SZ_W-1:0]   rnd, rem, heap_w;
   logic [SUM_W-1:0]  heap_s;

   assign acc      = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !init_req;
   assign init_ack = (state_ff == S_INIT);
   assign e_start  = rdata_ff[ENT_W-1 -: OFF_W];
   assign e_len    = rdata_ff[OWN_W +: LEN_W];
   assign e_own    = rdata_ff[OWN_W-1:0];
   assign rem      = SZ_W'(blen_ff) - size_ff;
   assign heap_w   = SZ_W'(heap_bytes);
   assign heap_s   = SUM_W'(heap_bytes);

   assign rsp.valid         = rv_ff;
   assign rsp.status        = rst_ff;
   assign rsp.result_offset = roff_ff;
   assign rsp.found         = rfound_ff;
   assign rsp.free_total    = rfree_ff;

   always_comb begin
      // pass transform of the owner field
      t_own = e_own;
      if (op_ff == OP_FREE && ep_ff == best_ff) begin
         t_own = '0;
      end else if (op_ff == OP_FREE_OWN && e_own == own_ff) begin
         t_own = '0;
      end else if (op_ff == OP_RENAME && e_own == own_ff) begin
         t_own = nown_ff;
      end
      rnd = (SZ_W'(req.request_bytes) + SZ_W'(3)) & ~SZ_W'(3);
      if (rnd < SZ_W'(MIN_PAYLOAD)) begin
         rnd = SZ_W'(MIN_PAYLOAD);
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; size_in = size_ff; own_in = own_ff; nown_in = nown_ff; pay_in = pay_ff;
      cnt_in = cnt_ff; rd_in = rd_ff; j_in = j_ff; dv_in = 1'b0; ep_in = ep_ff;
      best_in = best_ff; wr_in = wr_ff; have_in = have_ff; stop_in = stop_ff;
      hit_in = hit_ff; bad_in = bad_ff; bstart_in = bstart_ff; blen_in = blen_ff;
      hown_in = hown_ff; pos_in = pos_ff; used_in = used_ff; unused_in = unused_ff;
      pend_in = pend_ff; phave_in = phave_ff;
      rv_in = rv_ff; rst_in = rst_ff; roff_in = roff_ff; rfound_in = rfound_ff;
      rfree_in = rfree_ff;
      raddr = rd_ff[IDX_W-1:0];
      we = 1'b0; waddr = best_ff; wdata = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (init_req) begin
               state_in = S_INIT;
            end else if (acc) begin
               op_in = req.operation; own_in = req.owner_id; nown_in = req.new_owner_id;
               pay_in = req.payload_offset;
               size_in = rnd + SZ_W'(HDR_BYTES);
               rd_in = '0; have_in = 1'b0; stop_in = 1'b0; hit_in = 1'b0; bad_in = 1'b0;
               pos_in = '0; used_in = '0; unused_in = '0; phave_in = 1'b0; wr_in = '0;
               rst_in = ST_OK; roff_in = '0; rfound_in = 1'b0; rfree_in = '0;
               state_in = S_SCAN;
               case (req.operation)
                  OP_ALLOC: begin
                     if (req.request_bytes == '0 || req.owner_id == '0) begin
                        rst_in = ST_BAD_REQ; rv_in = 1'b1; state_in = S_RESP;
                     end
                  end
                  OP_FREE: begin
                     if (req.payload_offset < OFF_W'(HDR_BYTES)) begin
                        rst_in = ST_BAD_FREE; rv_in = 1'b1; state_in = S_RESP;
                     end
                  end
                  OP_FREE_OWN: begin
                     if (req.owner_id != '0 && req.owner_id <= OWN_W'(OWNER_MAX)) begin
                        state_in = S_PASS;
                     end
                  end
                  OP_EXISTS, OP_CHECK: ;
                  OP_RENAME: begin
                     if (req.owner_id == '0 || req.new_owner_id == '0) begin
                        rst_in = ST_BAD_REQ; rv_in = 1'b1; state_in = S_RESP;
                     end else begin
                        state_in = S_PASS;
                     end
                  end
                  default: begin
                     rst_in = ST_BAD_REQ; rv_in = 1'b1; state_in = S_RESP;
                  end
               endcase
            end
         end
         S_INIT: begin
            we = 1'b1; waddr = '0;
            wdata = {OFF_W'(0), heap_bytes, OWN_W'(0)};
            cnt_in = CNT_W'(1);
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (rd_ff < cnt_ff) begin
               dv_in = 1'b1; ep_in = rd_ff[IDX_W-1:0]; rd_in = rd_ff + CNT_W'(1);
            end else if (!dv_ff) begin
               state_in = S_DECIDE;
            end
            if (dv_ff) begin
               case (op_ff)
                  OP_ALLOC: begin
                     if (!stop_ff && e_own == '0 && SZ_W'(e_len) >= size_ff) begin
                        if (!fit_mode) begin
                           have_in = 1'b1; stop_in = 1'b1; best_in = ep_ff;
                           bstart_in = e_start; blen_in = e_len;
                        end else if (!have_ff || e_len < blen_ff) begin
                           have_in = 1'b1; best_in = ep_ff;
                           bstart_in = e_start; blen_in = e_len;
                           stop_in = (SZ_W'(e_len) - size_ff) < SZ_W'(SPLIT_MIN);
                        end
                     end
                  end
                  OP_FREE: begin
                     if (!hit_ff && e_start == pay_ff - OFF_W'(HDR_BYTES)) begin
                        hit_in = 1'b1; best_in = ep_ff; hown_in = e_own;
                     end
                  end
                  OP_CHECK: begin
                     if (SUM_W'(e_start) != pos_ff) begin
                        bad_in = 1'b1;
                     end
                     pos_in = pos_ff + SUM_W'(e_len);
                     if (e_own != '0) begin
                        used_in = used_ff + SUM_W'(e_len);
                     end else begin
                        unused_in = unused_ff + SUM_W'(e_len);
                     end
                  end
                  default: begin
                     if (e_own == own_ff) begin
                        hit_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_DECIDE: begin
            rv_in = 1'b1; state_in = S_RESP;
            case (op_ff)
               OP_ALLOC: begin
                  if (!have_ff) begin
                     rst_in = ST_NO_FIT;
                  end else if (rem >= SZ_W'(SPLIT_MIN)) begin
                     if (cnt_ff >= CNT_W'(MAX_BLOCKS)) begin
                        rst_in = ST_FULL;
                     end else begin
                        rv_in = 1'b0; j_in = cnt_ff; state_in = S_SHRD;
                     end
                  end else begin
                     rv_in = 1'b0; state_in = S_TAKE;
                  end
               end
               OP_FREE: begin
                  if (!hit_ff || hown_ff == '0 || hown_ff > OWN_W'(OWNER_MAX)) begin
                     rst_in = ST_BAD_FREE;
                  end else begin
                     rv_in = 1'b0; rd_in = '0; state_in = S_PASS;
                  end
               end
               OP_FREE_OWN: begin
                  rst_in = hit_ff ? ST_BAD_FREE : ST_OK;
               end
               OP_EXISTS: begin
                  rfound_in = hit_ff;
               end
               default: begin
                  if (bad_ff || pos_ff != heap_s || used_ff > heap_s
                      || heap_s - used_ff != unused_ff) begin
                     rst_in = ST_INCONS;
                  end else begin
                     rfree_in = unused_ff[LEN_W-1:0];
                  end
               end
            endcase
         end
         S_TAKE: begin
            we = 1'b1; waddr = best_ff; wdata = {bstart_ff, blen_ff, own_ff};
            roff_in = bstart_ff + OFF_W'(HDR_BYTES);
            rv_in = 1'b1; state_in = S_RESP;
         end
         S_SHRD: begin
            raddr = IDX_W'(j_ff - CNT_W'(1));
            if (j_ff > CNT_W'(best_ff) + CNT_W'(1)) begin
               state_in = S_SHWR;
            end else begin
               state_in = S_SPLIT_HI;
            end
         end
         S_SHWR: begin
            we = 1'b1; waddr = j_ff[IDX_W-1:0]; wdata = rdata_ff;
            j_in = j_ff - CNT_W'(1);
            state_in = S_SHRD;
         end
         S_SPLIT_HI: begin
            we = 1'b1; waddr = best_ff + IDX_W'(1);
            wdata = {bstart_ff + size_ff[OFF_W-1:0], rem[LEN_W-1:0], OWN_W'(0)};
            state_in = S_SPLIT_LO;
         end
         S_SPLIT_LO: begin
            we = 1'b1; waddr = best_ff; wdata = {bstart_ff, size_ff[LEN_W-1:0], own_ff};
            cnt_in = cnt_ff + CNT_W'(1);
            roff_in = bstart_ff + OFF_W'(HDR_BYTES);
            rv_in = 1'b1; state_in = S_RESP;
         end
         S_PASS: begin
            if (rd_ff < cnt_ff) begin
               dv_in = 1'b1; ep_in = rd_ff[IDX_W-1:0]; rd_in = rd_ff + CNT_W'(1);
            end else if (!dv_ff) begin
               state_in = S_PASSEND;
            end
            if (dv_ff) begin
               if (!phave_ff) begin
                  phave_in = 1'b1; pend_in = {e_start, e_len, t_own};
               end else if (op_ff != OP_RENAME && pend_ff[OWN_W-1:0] == '0 && t_own == '0) begin
                  pend_in[OWN_W +: LEN_W] = pend_ff[OWN_W +: LEN_W] + e_len;
               end else begin
                  we = 1'b1; waddr = wr_ff; wdata = pend_ff;
                  wr_in = wr_ff + IDX_W'(1);
                  pend_in = {e_start, e_len, t_own};
               end
            end
         end
         S_PASSEND: begin
            we = 1'b1; waddr = wr_ff; wdata = pend_ff;
            cnt_in = CNT_W'(wr_ff) + CNT_W'(1);
            rst_in = ST_OK; rv_in = 1'b1; state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) begin
               rv_in = 1'b0; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= CNT_W'(1);
         dv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         dv_ff    <= dv_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; size_ff <= size_in; own_ff <= own_in; nown_ff <= nown_in;
      pay_ff <= pay_in; rd_ff <= rd_in; j_ff <= j_in; ep_ff <= ep_in; best_ff <= best_in;
      wr_ff <= wr_in; have_ff <= have_in; stop_ff <= stop_in; hit_ff <= hit_in;
      bad_ff <= bad_in; bstart_ff <= bstart_in; blen_ff <= blen_in; hown_ff <= hown_in;
      pos_ff <= pos_in; used_ff <= used_in; unused_ff <= unused_in; pend_ff <= pend_in;
      phave_ff <= phave_in; rst_ff <= rst_in; roff_ff <= roff_in; rfound_ff <= rfound_in;
      rfree_ff <= rfree_in;
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= CNT_W'(MAX_BLOCKS)) else $error("block count out of range");
   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !rv_ff) else $error("response pending while idle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      acc |=> state_ff != S_IDLE) else $error("accepted beat left block idle");
   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPLIT_LO |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("split did not add an entry");
endmodule

FILE: rtl/block_heap_allocator.sv
// Block heap allocator top level: configuration registers and the engine.
// Depends on bha_pkg, bha_ifs and bha_engine.
`timescale 1ns / 1ps

// One request beat is taken at a time and answered by one response beat.
// Scans walk the block table one entry per cycle through a single memory
// read port. A split allocation moves each later table entry up by a read
// and a write; a free adds a compaction pass over the table. Writing
// heap_bytes reinitialises the table.
module block_heap_allocator #(
   parameter int MAX_BLOCKS     = bha_pkg::DEF_MAX_BLOCKS,
   parameter int MAX_HEAP_BYTES = bha_pkg::DEF_MAX_HEAP_BYTES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bha_req_if.sink                              req_ch,
   bha_rsp_if.source                            rsp_ch,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [$clog2(MAX_HEAP_BYTES+1)-1:0]  csr_wdata
);
   import bha_pkg::*;

   localparam int LEN_W = $clog2(MAX_HEAP_BYTES+1);

   logic             fit_ff, fit_in;
   logic [LEN_W-1:0] heap_ff, heap_in;
   logic             initp_ff, initp_in;
   logic             init_ack;

   always_comb begin
      fit_in   = fit_ff;
      heap_in  = heap_ff;
      initp_in = initp_ff && !init_ack;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIT_MODE: fit_in = csr_wdata[0];
            CSR_HEAP_SIZE: begin
               if (csr_wdata < LEN_W'(HEAP_MIN)) begin
                  heap_in = LEN_W'(HEAP_MIN);
               end else if (csr_wdata > LEN_W'(MAX_HEAP_BYTES)) begin
                  heap_in = LEN_W'(MAX_HEAP_BYTES);
               end else begin
                  heap_in = csr_wdata;
               end
               initp_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff   <= 1'b0;
         heap_ff  <= LEN_W'(HEAP_RESET);
         initp_ff <= 1'b1;
      end else begin
         fit_ff   <= fit_in;
         heap_ff  <= heap_in;
         initp_ff <= initp_in;
      end
   end

   bha_engine #(
      .MAX_BLOCKS     (MAX_BLOCKS),
      .MAX_HEAP_BYTES (MAX_HEAP_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fit_mode   (fit_ff),
      .heap_bytes (heap_ff),
      .init_req   (initp_ff),
      .init_ack   (init_ack),
      .req        (req_ch),
      .rsp        (rsp_ch)
   );
endmodule
